### hw/rtl/sfpl_pkg.sv
// shared types and constants for the stereo fade peak limiter
`timescale 1ns / 1ps

package sfpl_pkg;

  // configuration port geometry
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 25;

  // datapath operations issued by the sequencer, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FADE,
    OP_VOL,
    OP_MIX,
    OP_SCL,
    OP_SCR,
    OP_PEAK,
    OP_DIV,
    OP_LIM,
    OP_OUTL,
    OP_OUTR,
    OP_PCM
  } sfpl_op_t;

  // configuration values, already saturated to their legal ranges
  typedef struct packed {
    logic        play_on;
    logic [15:0] master_volume;
    logic [24:0] glide_coef;
    logic [24:0] attack_coef;
    logic [24:0] release_coef;
    logic [15:0] ceiling;
  } sfpl_cfg_t;

endpackage

### hw/rtl/sfpl_cfg.sv
// configuration register file with write-side saturation
`timescale 1ns / 1ps

module sfpl_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sfpl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sfpl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output sfpl_pkg::sfpl_cfg_t                 cfg
);

  localparam logic [sfpl_pkg::CFG_ADDR_W-1:0] REG_PLAY_ON  = 3'd0;
  localparam logic [sfpl_pkg::CFG_ADDR_W-1:0] REG_MVOL     = 3'd1;
  localparam logic [sfpl_pkg::CFG_ADDR_W-1:0] REG_GLIDE    = 3'd2;
  localparam logic [sfpl_pkg::CFG_ADDR_W-1:0] REG_ATTACK   = 3'd3;
  localparam logic [sfpl_pkg::CFG_ADDR_W-1:0] REG_RELEASE  = 3'd4;
  localparam logic [sfpl_pkg::CFG_ADDR_W-1:0] REG_CEILING  = 3'd5;

  localparam logic [15:0] UNITY_Q15 = 16'd32768;
  localparam logic [24:0] COEF_ONE  = 25'd16777216;

  localparam logic [15:0] RST_MVOL    = 16'd32768;
  localparam logic [24:0] RST_GLIDE   = 25'd8736;
  localparam logic [24:0] RST_ATTACK  = 25'd173860;
  localparam logic [24:0] RST_RELEASE = 25'd1748;
  localparam logic [15:0] RST_CEILING = 16'd31130;

  sfpl_pkg::sfpl_cfg_t cfg_r;
  logic [15:0]         q15_sat;
  logic [24:0]         coef_sat;

  // clamp to unity on the way in
  assign q15_sat  = (cfg_wdata[15:0] > UNITY_Q15) ? UNITY_Q15 : cfg_wdata[15:0];
  assign coef_sat = (cfg_wdata > COEF_ONE) ? COEF_ONE : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.play_on       <= 1'b0;
      cfg_r.master_volume <= RST_MVOL;
      cfg_r.glide_coef    <= RST_GLIDE;
      cfg_r.attack_coef   <= RST_ATTACK;
      cfg_r.release_coef  <= RST_RELEASE;
      cfg_r.ceiling       <= RST_CEILING;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PLAY_ON: cfg_r.play_on       <= cfg_wdata[0];
        REG_MVOL:    cfg_r.master_volume <= q15_sat;
        REG_GLIDE:   cfg_r.glide_coef    <= coef_sat;
        REG_ATTACK:  cfg_r.attack_coef   <= coef_sat;
        REG_RELEASE: cfg_r.release_coef  <= coef_sat;
        REG_CEILING: cfg_r.ceiling       <= q15_sat;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/sfpl_dp.sv
// datapath: shared multiplier, glides, limiter divider and pcm conversion
`timescale 1ns / 1ps

module sfpl_dp #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfpl_pkg::sfpl_op_t             op,
  input  sfpl_pkg::sfpl_cfg_t            cfg,
  input  logic signed [SAMPLE_WIDTH-1:0] mix_left,
  input  logic signed [SAMPLE_WIDTH-1:0] mix_right,
  input  logic                           buffer_end,
  output logic                           need_div,
  output logic signed [15:0]             pcm_left,
  output logic signed [15:0]             pcm_right,
  output logic                           limiting,
  output logic                           fade_active
);

  localparam int S    = SAMPLE_WIDTH;
  localparam int G    = GAIN_FRAC_BITS;
  localparam int GW   = G + 1;
  localparam int DW   = G + 2;
  localparam int AW   = (S > DW) ? S : DW;
  localparam int PW   = AW + DW;
  localparam int RW   = PW - G;
  localparam int D    = S - 19;
  localparam int NW   = 16 + G + D;
  localparam int PSH  = S - 4;
  localparam int CSHL = (G >= 24) ? G - 24 : 0;
  localparam int CSHR = (G >= 24) ? 0 : 24 - G;
  localparam int CXW  = 25 + CSHL;

  localparam logic [GW-1:0] ONE = {1'b1, {G{1'b0}}};
  localparam longint unsigned LTHR_L  = (97 * (longint'(1) << G) + 99) / 100;
  localparam longint unsigned FLOOR_L = (longint'(1) << G) / 100000;
  localparam logic [GW-1:0] LTHR  = GW'(LTHR_L);
  localparam logic [GW-1:0] FLOOR = GW'(FLOOR_L);
  localparam logic [PW-1:0] HALF  = PW'(1) << (G - 1);
  localparam logic [18:0]   PCM_CLIP = 19'd32439;

  function automatic logic [GW-1:0] to_gain(input logic [24:0] c);
    logic [CXW-1:0] x;
    x = CXW'(c) << CSHL;
    x = x >> CSHR;
    return GW'(x);
  endfunction

  // |v| * 32767 >> (S-4), clipped, sign restored
  function automatic logic [15:0] to_pcm(input logic signed [S-1:0] v);
    logic [S-1:0]  a;
    logic [S+14:0] m;
    logic [18:0]   p;
    logic [15:0]   c;
    a = v[S-1] ? -v : v;
    m = {a, 15'd0} - (S+15)'(a);
    p = 19'(m >> PSH);
    c = (p > PCM_CLIP) ? PCM_CLIP[15:0] : p[15:0];
    return v[S-1] ? -c : c;
  endfunction

  // gain state
  logic [GW-1:0]        fade_r, vol_r, lim_r, mg_r;
  logic                 flag_r;
  // per-item working registers
  logic signed [S-1:0]  in_l_r, in_r_r, sl_r, sr_r;
  logic                 bend_r;
  logic [S-1:0]         mag_r, rem_r;
  logic [G-1:0]         nlo_r;
  logic                 div_r;
  // output holding registers
  logic signed [15:0]   pcm_l_r, pcm_r_r;
  logic                 fact_r;

  logic [GW-1:0]        gc, vt, fade_tgt, need_val, lim_coef;
  logic signed [DW-1:0] fade_diff, vol_diff, lim_diff;
  logic signed [AW-1:0] mul_a;
  logic [GW-1:0]        mul_b, gl_cur;
  logic signed [PW-1:0] prod, prod_rs;
  logic signed [RW-1:0] rnd;
  logic signed [DW-1:0] gl_sum;
  logic [GW-1:0]        gl_new;
  logic signed [S-1:0]  smp_new;
  logic [S-1:0]         abs_l, abs_r, mag, n_hi;
  logic [NW-1:0]        n_full;
  logic [G-1:0]         n_lo;
  logic [S:0]           trial;
  logic                 trial_ge;

  assign gc       = to_gain(cfg.glide_coef);
  assign vt       = GW'(cfg.master_volume) << (G - 15);
  assign fade_tgt = cfg.play_on ? ONE : '0;
  assign need_val = div_r ? {1'b0, nlo_r} : ONE;
  assign lim_coef = (need_val < lim_r) ? to_gain(cfg.attack_coef)
                                       : to_gain(cfg.release_coef);

  assign fade_diff = $signed({1'b0, fade_tgt}) - $signed({1'b0, fade_r});
  assign vol_diff  = $signed({1'b0, vt}) - $signed({1'b0, vol_r});
  assign lim_diff  = $signed({1'b0, need_val}) - $signed({1'b0, lim_r});

  // operand selection for the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    gl_cur = '0;
    unique case (op)
      sfpl_pkg::OP_FADE: begin
        mul_a  = AW'(fade_diff);
        mul_b  = gc;
        gl_cur = fade_r;
      end
      sfpl_pkg::OP_VOL: begin
        mul_a  = AW'(vol_diff);
        mul_b  = gc;
        gl_cur = vol_r;
      end
      sfpl_pkg::OP_LIM: begin
        mul_a  = AW'(lim_diff);
        mul_b  = lim_coef;
        gl_cur = lim_r;
      end
      sfpl_pkg::OP_MIX: begin
        mul_a = AW'($signed({1'b0, fade_r}));
        mul_b = vol_r;
      end
      sfpl_pkg::OP_SCL: begin
        mul_a = AW'(in_l_r);
        mul_b = mg_r;
      end
      sfpl_pkg::OP_SCR: begin
        mul_a = AW'(in_r_r);
        mul_b = mg_r;
      end
      sfpl_pkg::OP_OUTL: begin
        mul_a = AW'(sl_r);
        mul_b = lim_r;
      end
      sfpl_pkg::OP_OUTR: begin
        mul_a = AW'(sr_r);
        mul_b = lim_r;
      end
      default: ;
    endcase
  end

  // product rounded half up, then one-pole accumulate
  assign prod    = mul_a * $signed({1'b0, mul_b});
  assign prod_rs = (prod + $signed(HALF)) >>> G;
  assign rnd     = prod_rs[RW-1:0];
  assign gl_sum  = $signed({1'b0, gl_cur}) + DW'(rnd);
  assign gl_new  = gl_sum[GW-1:0];
  assign smp_new = S'(rnd);

  // peak detect and divider setup
  assign abs_l  = sl_r[S-1] ? -sl_r : sl_r;
  assign abs_r  = sr_r[S-1] ? -sr_r : sr_r;
  assign mag    = (abs_l > abs_r) ? abs_l : abs_r;
  assign n_full = {cfg.ceiling, {(G + D){1'b0}}};
  assign n_hi   = S'(n_full[NW-1:G]);
  assign n_lo   = n_full[G-1:0];
  assign need_div = mag > n_hi;

  // one restoring step per cycle, quotient shifts into nlo_r
  assign trial    = {rem_r, nlo_r[G-1]};
  assign trial_ge = trial >= {1'b0, mag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r <= '0;
      vol_r  <= ONE;
      lim_r  <= ONE;
      flag_r <= 1'b0;
    end else begin
      unique case (op)
        sfpl_pkg::OP_FADE: fade_r <= gl_new;
        sfpl_pkg::OP_VOL:  vol_r  <= gl_new;
        sfpl_pkg::OP_LIM:  lim_r  <= gl_new;
        sfpl_pkg::OP_PCM:  if (bend_r) flag_r <= (lim_r < LTHR);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      sfpl_pkg::OP_LOAD: begin
        in_l_r <= mix_left;
        in_r_r <= mix_right;
        bend_r <= buffer_end;
      end
      sfpl_pkg::OP_MIX:  mg_r <= gl_new;
      sfpl_pkg::OP_SCL:  sl_r <= smp_new;
      sfpl_pkg::OP_SCR:  sr_r <= smp_new;
      sfpl_pkg::OP_PEAK: begin
        mag_r <= mag;
        rem_r <= n_hi;
        nlo_r <= n_lo;
        div_r <= need_div;
      end
      sfpl_pkg::OP_DIV: begin
        rem_r <= trial_ge ? S'(trial - {1'b0, mag_r}) : S'(trial);
        nlo_r <= {nlo_r[G-2:0], trial_ge};
      end
      sfpl_pkg::OP_OUTL: sl_r <= smp_new;
      sfpl_pkg::OP_OUTR: sr_r <= smp_new;
      sfpl_pkg::OP_PCM: begin
        pcm_l_r <= to_pcm(sl_r);
        pcm_r_r <= to_pcm(sr_r);
        fact_r  <= fade_r > FLOOR;
      end
      default: ;
    endcase
  end

  // mix gain product lands in mg_r, read back through gl_new with zero base
  assign pcm_left    = pcm_l_r;
  assign pcm_right   = pcm_r_r;
  assign limiting    = flag_r;
  assign fade_active = fact_r;

endmodule

### hw/rtl/sfpl_ctrl.sv
// sequencer for the per-frame datapath steps and the output handshake
`timescale 1ns / 1ps

module sfpl_ctrl #(
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  logic               need_div,
  output sfpl_pkg::sfpl_op_t op
);

  localparam int CNTW = $clog2(GAIN_FRAC_BITS);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(GAIN_FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FADE, S_VOL, S_MIX, S_SCL, S_SCR, S_PEAK,
    S_DIV, S_LIM, S_OUTL, S_OUTR, S_PCM
  } state_t;

  state_t          state_r;
  logic            out_valid_r;
  logic [CNTW-1:0] cnt_r;
  logic            out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    unique case (state_r)
      S_IDLE:  op = in_tvalid ? sfpl_pkg::OP_LOAD : sfpl_pkg::OP_NONE;
      S_FADE:  op = sfpl_pkg::OP_FADE;
      S_VOL:   op = sfpl_pkg::OP_VOL;
      S_MIX:   op = sfpl_pkg::OP_MIX;
      S_SCL:   op = sfpl_pkg::OP_SCL;
      S_SCR:   op = sfpl_pkg::OP_SCR;
      S_PEAK:  op = sfpl_pkg::OP_PEAK;
      S_DIV:   op = sfpl_pkg::OP_DIV;
      S_LIM:   op = sfpl_pkg::OP_LIM;
      S_OUTL:  op = sfpl_pkg::OP_OUTL;
      S_OUTR:  op = sfpl_pkg::OP_OUTR;
      S_PCM:   op = out_free ? sfpl_pkg::OP_PCM : sfpl_pkg::OP_NONE;
      default: op = sfpl_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) state_r <= S_FADE;
        S_FADE: state_r <= S_VOL;
        S_VOL:  state_r <= S_MIX;
        S_MIX:  state_r <= S_SCL;
        S_SCL:  state_r <= S_SCR;
        S_SCR:  state_r <= S_PEAK;
        S_PEAK: begin
          cnt_r   <= '0;
          state_r <= need_div ? S_DIV : S_LIM;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) state_r <= S_LIM;
        end
        S_LIM:  state_r <= S_OUTL;
        S_OUTL: state_r <= S_OUTR;
        S_OUTR: state_r <= S_PCM;
        S_PCM:  if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase

      if (state_r == S_PCM && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

### hw/rtl/stereo_fade_peak_limiter_top.sv
// top level: stereo fade, volume glide and peak limiter to 16-bit pcm
// each frame steps through fade, volume, mix, scale left, scale right, peak, limiter,
//   output left, output right, pcm; restoring divide steps follow peak when the peak
//   exceeds the ceiling and the limiter target needs a division, one quotient bit per
//   cycle; a new frame is taken only in idle, after the pcm step of the previous one
// reset: rst_n synchronous active low; gains go to fade 0, volume 1, limiter 1
`timescale 1ns / 1ps

module stereo_fade_peak_limiter_top #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: mix_left [SAMPLE_WIDTH-1:0], mix_right next, zero pad to bytes
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  in_tdata,
  input  logic                                 in_tlast,    // buffer_end
  // out_tdata: pcm_left [15:0], pcm_right [31:16]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [31:0]                          out_tdata,
  // out_tuser: limiting [0], fade_active [1]
  output logic [1:0]                           out_tuser,
  // register write port, no read-back
  input  logic                                 cfg_we,
  input  logic [sfpl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sfpl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  sfpl_pkg::sfpl_cfg_t cfg;
  sfpl_pkg::sfpl_op_t  op;
  logic                need_div;
  logic signed [15:0]  pcm_left, pcm_right;
  logic                limiting, fade_active;

  // configuration registers, saturated on write
  sfpl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer: one datapath step per cycle unless stalled, holds out_tvalid
  sfpl_ctrl #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .need_div   (need_div),
    .op         (op)
  );

  // datapath: gains, shared multiplier, divider, output registers;
  // the output registers let the next frame be taken while a result waits
  sfpl_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .cfg         (cfg),
    .mix_left    ($signed(in_tdata[SAMPLE_WIDTH-1:0])),
    .mix_right   ($signed(in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
    .buffer_end  (in_tlast),
    .need_div    (need_div),
    .pcm_left    (pcm_left),
    .pcm_right   (pcm_right),
    .limiting    (limiting),
    .fade_active (fade_active)
  );

  assign out_tdata = {pcm_right, pcm_left};
  assign out_tuser = {fade_active, limiting};

endmodule

### test/stereo_fade_peak_limiter_top_tb.sv
// self-checking testbench for the stereo fade peak limiter top level
`timescale 1ns / 1ps

module stereo_fade_peak_limiter_top_tb;

  // gains are Q1.24, samples Q4.20, pcm scale 32767 clipped at 32439
  localparam longint UNITY       = 64'sd1 << 24;
  localparam longint FADE_FLOOR  = UNITY / 100000;
  localparam longint LIMIT_THR   = (97 * UNITY + 99) / 100;
  localparam longint PCM_FULL    = 32767;
  localparam longint PCM_CLIP    = 32439;
  localparam int     WATCHDOG_CYCLES = 2000;
  localparam int     SETTLE_CYCLES   = 40;   // extra wait once the block has drained

  localparam logic [23:0] MIX_MAX   = 24'h7FFFFF;
  localparam logic [23:0] MIX_MIN   = 24'h800000;
  localparam logic [23:0] MIX_UNITY = 24'h100000;
  localparam logic [24:0] COEF_ONE  = 25'h1000000;
  localparam logic [24:0] COEF_MAX  = 25'h1FFFFFF;

  // register map of the write port, the two top indexes decode to nothing
  typedef enum logic [2:0] {
    REG_PLAY_ON,
    REG_MASTER_VOLUME,
    REG_GLIDE_COEF,
    REG_ATTACK_COEF,
    REG_RELEASE_COEF,
    REG_CEILING,
    REG_SPARE6,
    REG_SPARE7
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
    logic        last;
  } mix_frame_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        limiting;
    logic        fade_active;
  } pcm_frame_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // in_tdata: mix_left [23:0], mix_right [47:24]
  logic [47:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_tdata: pcm_left [15:0], pcm_right [31:16]
  logic [31:0] out_tdata;
  // out_tuser: limiting [0], fade_active [1]
  logic [1:0]  out_tuser;
  logic        cfg_we     = 1'b0;
  logic [sfpl_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [sfpl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  stereo_fade_peak_limiter_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor state: register copy plus the three gains and the latched flag
  // ---------------------------------------------------------------------------
  sfpl_pkg::sfpl_cfg_t cfg_m;
  longint fade_lvl  = 0;
  longint vol_lvl   = UNITY;      // master volume resets to unity
  longint lim_gain  = UNITY;
  logic   lim_flag  = 1'b0;

  mix_frame_t mix_pending_q[$];   // frames waiting for the driver
  pcm_frame_t pcm_due_q[$];       // predicted pcm frames, oldest first

  int  frames_queued  = 0;
  int  frames_taken   = 0;
  int  buffer_ends    = 0;
  int  limiting_seen  = 0;
  int  settings_run   = 0;
  int  mismatches     = 0;
  int  quiet_cycles   = 0;
  bit  in_taken       = 1'b0;     // input transaction at the last rising edge
  bit  idle_en        = 1'b1;     // random gaps and stalls allowed
  int  in_gap         = 0;
  int  ready_hold     = 0;

  // half-up rounding shift by the gain fraction width
  function automatic longint round_q24(longint v);
    return (v + (64'sd1 << 23)) >>> 24;
  endfunction

  function automatic longint coef_q24(logic [24:0] c);
    return (c > COEF_ONE) ? UNITY : longint'(c);
  endfunction

  function automatic longint sat_unity(logic [15:0] v);
    return (v > 16'd32768) ? 64'sd32768 : longint'(v);
  endfunction

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // one-pole step toward a target
  function automatic longint glide_to(longint cur, longint tgt, longint coef);
    return cur + round_q24((tgt - cur) * coef);
  endfunction

  // Q4.20 to pcm: scale, truncate toward zero, clip to +-0.99
  function automatic logic [15:0] q20_to_pcm(longint v);
    longint p;
    p = (mag_of(v) * PCM_FULL) >>> 20;
    if (p > PCM_CLIP)
      p = PCM_CLIP;
    if (v < 0)
      p = -p;
    return p[15:0];
  endfunction

  // advances the gains by one frame and returns the pcm frame it produces
  function automatic pcm_frame_t fade_limit_pcm(logic [23:0] l, logic [23:0] r, logic last);
    pcm_frame_t res;
    longint gc, mg, sl, sr, peak, need, ceil_q, coef;
    gc       = coef_q24(cfg_m.glide_coef);
    fade_lvl = glide_to(fade_lvl, cfg_m.play_on ? UNITY : 64'sd0, gc);
    vol_lvl  = glide_to(vol_lvl, sat_unity(cfg_m.master_volume) << 9, gc);
    mg       = round_q24(fade_lvl * vol_lvl);
    sl       = round_q24(longint'($signed(l)) * mg);
    sr       = round_q24(longint'($signed(r)) * mg);

    // limiter target: ceiling over peak, ceiling in Q1.15 lifted to Q4.20
    peak   = (mag_of(sl) > mag_of(sr)) ? mag_of(sl) : mag_of(sr);
    ceil_q = sat_unity(cfg_m.ceiling);
    need   = UNITY;
    if (peak > (ceil_q << 5))
      need = ((ceil_q << 24) << 5) / peak;
    coef     = (need < lim_gain) ? coef_q24(cfg_m.attack_coef) : coef_q24(cfg_m.release_coef);
    lim_gain = glide_to(lim_gain, need, coef);

    sl = round_q24(sl * lim_gain);
    sr = round_q24(sr * lim_gain);
    if (last)
      lim_flag = (lim_gain < LIMIT_THR);

    res.left        = q20_to_pcm(sl);
    res.right       = q20_to_pcm(sr);
    res.limiting    = lim_flag;
    res.fade_active = (fade_lvl > FADE_FLOOR);
    return res;
  endfunction

  task automatic check_field(string what, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver: presents queued frames at the falling edge, random gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : in_driver
    mix_frame_t nxt;
    if (!rst_n || (in_tvalid && !in_taken)) begin
      // in reset, or the current transaction is still waiting for ready
    end else if (in_gap != 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (mix_pending_q.size() != 0) begin
      nxt = mix_pending_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= {nxt.right, nxt.left};
      in_tlast  <= nxt.last;
      // schedule a gap after this transaction now and then
      if (idle_en && $urandom_range(0, 5) == 0)
        in_gap = $urandom_range(1, 15);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result side backpressure: bursts of low ready
  always @(negedge clk) begin : out_stall
    if (ready_hold != 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if (rst_n && idle_en && $urandom_range(0, 9) == 0) begin
      ready_hold = $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each input transaction, checks each result, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    pcm_frame_t want;
    bit out_taken;
    in_taken  = rst_n && in_tvalid && in_tready;
    out_taken = rst_n && out_tvalid && out_tready;
    if (in_taken) begin
      pcm_due_q.push_back(fade_limit_pcm(in_tdata[23:0], in_tdata[47:24], in_tlast));
      frames_taken++;
      if (in_tlast)
        buffer_ends++;
    end
    if (out_taken) begin
      if (pcm_due_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected pcm transaction: expected none actual data %h user %b",
                 $time, out_tdata, out_tuser);
      end else begin
        want = pcm_due_q.pop_front();
        check_field("pcm_left", $signed(want.left), $signed(out_tdata[15:0]));
        check_field("pcm_right", $signed(want.right), $signed(out_tdata[31:16]));
        check_field("limiting", want.limiting, out_tuser[0]);
        check_field("fade_active", want.fade_active, out_tuser[1]);
        if (out_tuser[0] === 1'b1)
          limiting_seen++;
      end
    end
    // watchdog: too long without any transaction on either side
    if (rst_n) begin
      if (in_taken || out_taken)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t watchdog: no transaction for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pcm_due_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // register write at the falling edge; the copy is updated once it has landed
  task automatic write_reg(reg_idx_t idx, logic [24:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PLAY_ON:       cfg_m.play_on       = val[0];
      REG_MASTER_VOLUME: cfg_m.master_volume = val[15:0];
      REG_GLIDE_COEF:    cfg_m.glide_coef    = val;
      REG_ATTACK_COEF:   cfg_m.attack_coef   = val;
      REG_RELEASE_COEF:  cfg_m.release_coef  = val;
      REG_CEILING:       cfg_m.ceiling       = val[15:0];
      default: ;         // unmapped index, no effect
    endcase
  endtask

  task automatic queue_frame(logic [23:0] l, logic [23:0] r, logic last);
    mix_frame_t f;
    f.left  = l;
    f.right = r;
    f.last  = last;
    mix_pending_q.push_back(f);
    frames_queued++;
  endtask

  // block drained: every frame taken, every result back, divider settled
  task automatic wait_idle();
    while (frames_taken != frames_queued || pcm_due_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // sample mix weighted toward the interesting regions around the ceiling
  function automatic logic [23:0] mix_sample();
    int v;
    v = 0;
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: v = $urandom_range(0, 262143);
      2: v = $urandom_range(900000, 1200000);
      3: return $urandom_range(0, 1) ? MIX_MAX : MIX_MIN;
      4: v = $urandom_range(1200000, 8388607);
      default: v = $urandom_range(0, 3);
    endcase
    if ($urandom_range(0, 1))
      v = -v;
    return 24'(v);
  endfunction

  // coefficient: zero, exactly one, above one (saturates), slow and general
  function automatic logic [24:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 25'd0;
      1: return COEF_ONE;
      2: return 25'($urandom_range(32'h1000001, 32'h1FFFFFF));
      3: return 25'($urandom_range(1, 32'h1000000));
      default: return 25'($urandom_range(500, 400000));
    endcase
  endfunction

  // Q1.15 value with unity and above-unity cases
  function automatic logic [15:0] unity_field();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(16000, 32768));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence: reset, directed settings, then random settings
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int ph, n, k, blen;
    logic pon;
    cfg_m = '{play_on: 1'b0, master_volume: 16'd32768, glide_coef: 25'd8736,
              attack_coef: 25'd173860, release_coef: 25'd1748, ceiling: 16'd31130};

    // reset held low from the start, released at a falling edge
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: fade starts from silence, play off
    @(posedge clk);
    queue_frame(MIX_MAX, MIX_MIN, 1'b1);
    queue_frame(24'd0, 24'd0, 1'b0);
    queue_frame(MIX_UNITY, -MIX_UNITY, 1'b1);
    wait_idle();
    settings_run++;

    // instant glide, hard attack, frozen release, volume and ceiling above unity
    write_reg(REG_PLAY_ON, 25'd1);
    write_reg(REG_MASTER_VOLUME, 25'd65535);
    write_reg(REG_GLIDE_COEF, COEF_MAX);
    write_reg(REG_ATTACK_COEF, COEF_MAX);
    write_reg(REG_RELEASE_COEF, 25'd0);
    write_reg(REG_CEILING, 25'd65535);
    @(posedge clk);
    queue_frame(MIX_MAX, MIX_MAX, 1'b0);
    queue_frame(MIX_MIN, MIX_MIN, 1'b1);
    queue_frame(MIX_MAX, 24'd0, 1'b0);
    queue_frame(24'd0, MIX_MIN, 1'b1);
    queue_frame(24'd1, -24'd1, 1'b0);
    queue_frame(-24'd1, 24'd1, 1'b1);
    queue_frame(24'd0, 24'd0, 1'b1);
    queue_frame(MIX_UNITY, MIX_UNITY - 24'd1, 1'b1);
    wait_idle();
    settings_run++;

    // zero ceiling: any nonzero peak drives the target to zero; unmapped indexes
    write_reg(REG_CEILING, 25'd0);
    write_reg(REG_RELEASE_COEF, COEF_ONE);
    write_reg(REG_ATTACK_COEF, 25'h0800000);
    write_reg(REG_SPARE6, COEF_MAX);
    write_reg(REG_SPARE7, 25'h0AAAAAA);
    @(posedge clk);
    queue_frame(24'd0, 24'd0, 1'b1);
    queue_frame(24'd3, -24'd2, 1'b1);
    queue_frame(MIX_MAX, MIX_MIN, 1'b0);
    queue_frame(24'd0, 24'd0, 1'b1);
    wait_idle();
    settings_run++;

    // play off with an instant glide: fade drops to silence at once
    write_reg(REG_PLAY_ON, 25'd0);
    write_reg(REG_MASTER_VOLUME, 25'd0);
    @(posedge clk);
    queue_frame(MIX_MAX, MIX_MAX, 1'b1);
    queue_frame(MIX_MIN, 24'd5, 1'b0);
    queue_frame(24'h123456, 24'hFEDCBA, 1'b1);
    wait_idle();
    settings_run++;

    // random settings, each followed by buffers of random frames
    for (ph = 0; ph < 10; ph++) begin
      pon = (ph == 0) || ($urandom_range(0, 3) != 0);
      write_reg(REG_PLAY_ON, {24'($urandom), pon});
      write_reg(REG_MASTER_VOLUME, {9'($urandom), unity_field()});
      write_reg(REG_GLIDE_COEF, rand_coef());
      write_reg(REG_ATTACK_COEF, rand_coef());
      write_reg(REG_RELEASE_COEF, rand_coef());
      write_reg(REG_CEILING, {9'($urandom), unity_field()});
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, 25'($urandom));
      @(posedge clk);
      idle_en = (ph != 9);      // last setting runs at full rate
      n = 0;
      while (n < 53) begin
        blen = $urandom_range(1, 12);
        for (k = 0; k < blen; k++)
          queue_frame(mix_sample(), mix_sample(), k == blen - 1);
        n += blen;
      end
      wait_idle();
      settings_run++;
    end

    $display("covered %0d frames in %0d buffers over %0d register settings",
             frames_taken, buffer_ends, settings_run);
    $display("%0d results carried the limiting flag, %0d mismatches", limiting_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
